// ----- rtl/lec_pkg.sv -----
// ----------------------------------------------------------------------------
// lec_pkg
// Shared constants and command word tables for the line edit command
// recognizer.
// ----------------------------------------------------------------------------
package lec_pkg;

	localparam int BUF_SIZE_DEF = 32;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_HELP   = 3'd1;
	localparam logic [2:0] CMD_STATUS = 3'd2;
	localparam logic [2:0] CMD_OPEN   = 3'd3;
	localparam logic [2:0] CMD_CLOSE  = 3'd4;
	localparam logic [2:0] CMD_STUCK  = 3'd5;

	// word slots: help, h, status, s, open, o, close, c, stuck, st
	localparam int NUM_WORDS = 10;
	localparam int MAX_WORD  = 6;

	function automatic logic [2:0] word_len(input logic [3:0] w);
		logic [2:0] n;
		begin
			unique case (w)
				4'd0:    n = 3'd4;
				4'd1:    n = 3'd1;
				4'd2:    n = 3'd6;
				4'd3:    n = 3'd1;
				4'd4:    n = 3'd4;
				4'd5:    n = 3'd1;
				4'd6:    n = 3'd5;
				4'd7:    n = 3'd1;
				4'd8:    n = 3'd5;
				4'd9:    n = 3'd2;
				default: n = 3'd0;
			endcase
			return n;
		end
	endfunction

	function automatic logic [2:0] word_cmd(input logic [3:0] w);
		logic [2:0] c;
		begin
			unique case (w)
				4'd0, 4'd1: c = CMD_HELP;
				4'd2, 4'd3: c = CMD_STATUS;
				4'd4, 4'd5: c = CMD_OPEN;
				4'd6, 4'd7: c = CMD_CLOSE;
				4'd8, 4'd9: c = CMD_STUCK;
				default:    c = CMD_NONE;
			endcase
			return c;
		end
	endfunction

	// character p of word w; zero past the end of the word
	function automatic logic [6:0] word_char(input logic [3:0] w, input logic [2:0] p);
		logic [47:0] s;
		logic [2:0]  n;
		logic [7:0]  b;
		begin
			n = word_len(w);
			unique case (w)
				4'd0:    s = 48'("help");
				4'd1:    s = 48'("h");
				4'd2:    s = 48'("status");
				4'd3:    s = 48'("s");
				4'd4:    s = 48'("open");
				4'd5:    s = 48'("o");
				4'd6:    s = 48'("close");
				4'd7:    s = 48'("c");
				4'd8:    s = 48'("stuck");
				4'd9:    s = 48'("st");
				default: s = 48'd0;
			endcase
			b = 8'd0;
			if (p < n) begin
				b = s[8 * (n - 3'd1 - p) +: 8];
			end
			return b[6:0];
		end
	endfunction

endpackage

// ----- rtl/line_edit_command_recognizer.sv -----
// ----------------------------------------------------------------------------
// line_edit_command_recognizer
// Command line editor for a serial console: folds case, appends printable
// characters, handles backspace, and decodes a command word at line end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, rx_byte) takes one received byte per
//   beat. Output channel (out_valid/out_stall) delivers result beats with
//   echo_valid, echo_char, line_end, command and last; last marks the final
//   beat caused by one input byte.
//   Printable byte, line not full: one echo beat, the cycle after acceptance.
//   Backspace/delete on a non-empty line: three beats (BS, SP, BS), each
//   issued once the output register is free.
//   CR/LF: one line_end beat. A line that can match a command word is read
//   back from the line memory one character per cycle (S_RD), then S_CMP
//   and S_END issue the beat; otherwise it comes the cycle after acceptance.
//   One byte is handled at a time; a new byte is taken once the previous
//   byte's beats are issued and the output register is free. An erase
//   waits in S_BS, and a matched line end passes S_RD, S_CMP and S_END,
//   its read paced by the single read port of the line memory.
//   Reset clears the line length and the output valid flag; the character
//   memory needs no clearing. A stalled output beat holds, and the input
//   stalls until it is taken.
// ----------------------------------------------------------------------------
module line_edit_command_recognizer #(
	parameter int BUF_SIZE = lec_pkg::BUF_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       echo_valid,
	output logic [6:0] echo_char,
	output logic       line_end,
	output logic [2:0] command,
	output logic       last
);

	localparam int DEPTH  = BUF_SIZE - 1;
	localparam int LEN_W  = $clog2(BUF_SIZE);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [LEN_W-1:0] CAP = LEN_W'(DEPTH);
	localparam int NW = lec_pkg::NUM_WORDS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BS   = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_END  = 3'd4;

	logic [6:0]        mem [DEPTH];
	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [6:0]        rd_data_s1;
	logic              chk_vld_s1;
	logic [2:0]        chk_idx_s1;

	logic [2:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [1:0]       bs_cnt_q;
	logic [2:0]       rd_idx_q;
	logic [NW-1:0]    alive_q;
	logic [NW-1:0]    alive_init;
	logic [NW-1:0]    alive_keep;

	logic       out_vld_q;
	logic       ev_q;
	logic [6:0] ec_q;
	logic       le_q;
	logic [2:0] cmd_q;
	logic       last_q;

	logic       out_free;
	logic       out_load;
	logic       accept;
	logic [7:0] ch;
	logic       is_bs;
	logic       is_eol;
	logic       is_prn;
	logic [2:0] match_cmd;

	assign out_free = !out_vld_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		ch = rx_byte;
		if (rx_byte >= lec_pkg::CH_UC_A && rx_byte <= lec_pkg::CH_UC_Z) begin
			ch = rx_byte + lec_pkg::CASE_OFS;
		end
	end

	assign is_bs  = (rx_byte == lec_pkg::CH_BS) || (rx_byte == lec_pkg::CH_DEL);
	assign is_eol = (rx_byte == lec_pkg::CH_CR) || (rx_byte == lec_pkg::CH_LF);
	assign is_prn = (ch >= lec_pkg::CH_SPACE) && (ch <= lec_pkg::CH_TILDE);
	assign wr_en  = accept && !is_bs && !is_eol && is_prn && (len_q < CAP);
	assign rd_addr = ADDR_W'(rd_idx_q);

	// a new result beat enters the output register
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				out_load = accept && (is_bs ? (len_q != '0) :
					(is_eol ? (alive_init == '0) : wr_en));
			end
			S_BS, S_END: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int w = 0; w < NW; w++) begin
			alive_init[w] = (len_q == LEN_W'(lec_pkg::word_len(4'(w))));
			alive_keep[w] = (rd_data_s1 == lec_pkg::word_char(4'(w), chk_idx_s1));
		end
	end

	always_comb begin
		match_cmd = lec_pkg::CMD_NONE;
		for (int w = 0; w < NW; w++) begin
			if (alive_q[w]) begin
				match_cmd = lec_pkg::word_cmd(4'(w));
			end
		end
	end

	// line memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[len_q[ADDR_W-1:0]] <= ch[6:0];
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		if (accept && is_eol) begin
			alive_q <= alive_init;
		end else if (chk_vld_s1) begin
			alive_q <= alive_q & alive_keep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			bs_cnt_q   <= '0;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == S_RD);
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (is_bs) begin
							if (len_q != '0) begin
								len_q    <= len_q - 1'b1;
								bs_cnt_q <= 2'd1;
								state_q  <= S_BS;
							end
						end else if (is_eol) begin
							if (alive_init != '0) begin
								rd_idx_q <= '0;
								state_q  <= S_RD;
							end else begin
								len_q <= '0;
							end
						end else if (wr_en) begin
							len_q <= len_q + 1'b1;
						end
					end
				end
				S_BS: begin
					if (out_free) begin
						bs_cnt_q <= bs_cnt_q + 1'b1;
						if (bs_cnt_q == 2'd2) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RD: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (LEN_W'(rd_idx_q) + LEN_W'(1) == len_q) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_END;
				end
				S_END: begin
					if (out_free) begin
						len_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (is_bs) begin
						ev_q   <= 1'b1;
						ec_q   <= lec_pkg::CH_BS[6:0];
						le_q   <= 1'b0;
						cmd_q  <= lec_pkg::CMD_NONE;
						last_q <= 1'b0;
					end else if (is_eol) begin
						ev_q   <= 1'b0;
						ec_q   <= '0;
						le_q   <= 1'b1;
						cmd_q  <= lec_pkg::CMD_NONE;
						last_q <= 1'b1;
					end else begin
						ev_q   <= 1'b1;
						ec_q   <= ch[6:0];
						le_q   <= 1'b0;
						cmd_q  <= lec_pkg::CMD_NONE;
						last_q <= 1'b1;
					end
				end
			end
			S_BS: begin
				if (out_free) begin
					ev_q   <= 1'b1;
					ec_q   <= (bs_cnt_q == 2'd1) ? lec_pkg::CH_SPACE[6:0] : lec_pkg::CH_BS[6:0];
					le_q   <= 1'b0;
					cmd_q  <= lec_pkg::CMD_NONE;
					last_q <= (bs_cnt_q == 2'd2);
				end
			end
			S_END: begin
				if (out_free) begin
					ev_q   <= 1'b0;
					ec_q   <= '0;
					le_q   <= 1'b1;
					cmd_q  <= match_cmd;
					last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_vld_q;
	assign echo_valid = ev_q;
	assign echo_char  = ec_q;
	assign line_end   = le_q;
	assign command    = cmd_q;
	assign last       = last_q;

endmodule

// ----- rtl/lec_checker.sv -----
// ----------------------------------------------------------------------------
// lec_checker
// Port-level checks on result beats of the line edit command recognizer.
// ----------------------------------------------------------------------------
module lec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       echo_valid,
	input logic [6:0] echo_char,
	input logic       line_end,
	input logic [2:0] command,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(echo_valid) && $stable(echo_char)
			&& $stable(line_end) && $stable(command) && $stable(last))
		else $error("stalled result beat changed");

	a_eol_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> last && !echo_valid && (echo_char == 7'd0))
		else $error("line end beat malformed");

	a_cmd_only_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_end |-> (command == lec_pkg::CMD_NONE) && echo_valid)
		else $error("command code outside line end");

	a_bs_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && echo_valid && !last
			|-> (echo_char == lec_pkg::CH_BS[6:0]) || (echo_char == lec_pkg::CH_SPACE[6:0]))
		else $error("non-final beat is not part of erase sequence");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command <= lec_pkg::CMD_STUCK))
		else $error("command code out of range");

endmodule

bind line_edit_command_recognizer lec_checker u_lec_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.echo_valid (echo_valid),
	.echo_char  (echo_char),
	.line_end   (line_end),
	.command    (command),
	.last       (last)
);
